// ----- src/fae_pkg.sv -----
// ----------------------------------------------------------------------------
// fae_pkg: shared types and constants for the FAT entry access block
// Operation, table kind and status codes, the request and result payloads,
// and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package fae_pkg;

    // Default geometry
    localparam int STORE_BYTES_DEF   = 8192;
    localparam int FIRST_CLUSTER_DEF = 2;

    // Widest byte address over the supported store sizes (up to 1 MiB)
    localparam int ADDR_MAX_W  = 20;
    localparam int CLUSTER_W   = 28;
    localparam int ENTRY_W     = 28;
    localparam int LOAD_ADDR_W = 13;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_FAT12 = 2'd0,
        KIND_FAT16 = 2'd1,
        KIND_FAT32 = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CLUSTER = 2'd1,
        ST_BAD_KIND    = 2'd2
    } t_status;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_KIND  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]             operation;
        logic [CLUSTER_W-1:0]   cluster;
        logic [ENTRY_W-1:0]     entry_in;
        logic [LOAD_ADDR_W-1:0] load_address;
        logic [7:0]             load_byte;
    } t_fae_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] entry_out;
        logic               dirty;
    } t_fae_res;

    // Classified command: byte address of the entry or raw byte, new value
    typedef struct packed {
        t_op                   op;
        t_status               status;
        t_kind                 kind;
        logic                  odd;
        logic [ADDR_MAX_W-1:0] addr;
        logic [ENTRY_W-1:0]    value;
    } t_fae_cmd;

endpackage

// ----- src/fae_front.sv -----
// ----------------------------------------------------------------------------
// fae_front: request classifier
// Checks the cluster range and table kind, works out the byte offset of the
// entry and whether it fits in the store, and builds the command word.
// ----------------------------------------------------------------------------
module fae_front
    import fae_pkg::*;
#(
    parameter int STORE_BYTES   = STORE_BYTES_DEF,
    parameter int FIRST_CLUSTER = FIRST_CLUSTER_DEF
) (
    input  t_fae_req             i_req,
    input  t_kind                i_kind,
    input  logic [CLUSTER_W-1:0] i_cluster_count,
    output t_fae_cmd             o_cmd
);

    // Highest legal start offset for two- and four-byte entries
    localparam logic [30:0] LIM2     = 31'(STORE_BYTES - 2);
    localparam logic [30:0] LIM4     = 31'(STORE_BYTES - 4);
    localparam logic [30:0] LOAD_LIM = 31'(STORE_BYTES);

    logic [CLUSTER_W:0]   hi_bound;
    logic                 in_range;
    logic [CLUSTER_W+1:0] c3;
    logic [CLUSTER_W+1:0] off;
    logic                 past_end;
    t_status              status;

    // Range check: FIRST_CLUSTER <= cluster < FIRST_CLUSTER + count
    assign hi_bound = (CLUSTER_W+1)'(FIRST_CLUSTER) + {1'b0, i_cluster_count};
    assign in_range = (i_req.cluster >= CLUSTER_W'(FIRST_CLUSTER)) &&
                      ({1'b0, i_req.cluster} < hi_bound);

    // cluster * 3 for the packed 12-bit layout
    assign c3 = {2'b00, i_req.cluster} + {1'b0, i_req.cluster, 1'b0};

    // Entry offset and store bound per table kind
    always_comb begin
        case (i_kind)
            KIND_FAT12: begin
                off      = {1'b0, c3[CLUSTER_W+1:1]};
                past_end = {1'b0, off} > LIM2;
            end
            KIND_FAT16: begin
                off      = {1'b0, i_req.cluster, 1'b0};
                past_end = {1'b0, off} > LIM2;
            end
            KIND_FAT32: begin
                off      = {i_req.cluster, 2'b00};
                past_end = {1'b0, off} > LIM4;
            end
            default: begin
                off      = '0;
                past_end = 1'b0;
            end
        endcase
    end

    // Status by operation; range check comes before the kind check
    always_comb begin
        case (t_op'(i_req.operation))
            OP_READ, OP_WRITE: begin
                if (!in_range) begin
                    status = ST_BAD_CLUSTER;
                end else if (i_kind == KIND_NONE) begin
                    status = ST_BAD_KIND;
                end else if (past_end) begin
                    status = ST_BAD_CLUSTER;
                end else begin
                    status = ST_OK;
                end
            end
            OP_LOAD: begin
                if ({18'b0, i_req.load_address} >= LOAD_LIM) begin
                    status = ST_BAD_CLUSTER;
                end else begin
                    status = ST_OK;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Build the command word
    always_comb begin
        o_cmd.op     = t_op'(i_req.operation);
        o_cmd.status = status;
        o_cmd.kind   = i_kind;
        o_cmd.odd    = i_req.cluster[0];
        if (t_op'(i_req.operation) == OP_LOAD) begin
            o_cmd.addr  = ADDR_MAX_W'(i_req.load_address);
            o_cmd.value = ENTRY_W'(i_req.load_byte);
        end else begin
            o_cmd.addr  = off[ADDR_MAX_W-1:0];
            o_cmd.value = i_req.entry_in;
        end
    end

endmodule

// ----- src/fae_queue.sv -----
// ----------------------------------------------------------------------------
// fae_queue: two-entry command queue
// Decouples the classifier from the table back end.
// ----------------------------------------------------------------------------
module fae_queue
    import fae_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_fae_cmd i_cmd,
    input  logic     i_pop,
    output t_fae_cmd o_head,
    output logic     o_avail,
    output logic     o_full
);

    t_fae_cmd   r_buf [2];
    logic       r_wr;
    logic       n_wr;
    logic       r_rd;
    logic       n_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_head  = r_buf[r_rd];
    assign o_avail = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    // Advance pointers and count
    always_comb begin
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Hold the command payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("command popped from an empty queue");

endmodule

// ----- src/fae_back.sv -----
// ----------------------------------------------------------------------------
// fae_back: table back end
// Holds the byte store as four byte lanes, clears it after reset, and runs
// each command as a read step followed by an execute/write-back step.
// ----------------------------------------------------------------------------
module fae_back
    import fae_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_avail,
    input  t_fae_cmd i_head,
    output logic     o_pop,
    output logic     o_clearing,
    output logic     o_done,
    output t_fae_res o_res
);

    localparam int BA_W  = $clog2(STORE_BYTES);
    localparam int ROW_W = BA_W - 2;
    localparam int ROWS  = (STORE_BYTES + 3) / 4;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_FETCH = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [ROW_W-1:0] r_clr_row;
    logic [ROW_W-1:0] n_clr_row;
    logic             r_dirty;
    logic             n_dirty;
    logic             r_done;
    t_fae_cmd         r_cmd;
    t_fae_res         r_res;
    t_fae_res         n_res;
    logic [7:0]       r_rdata [4];

    logic [ROW_W-1:0] rd_row [4];
    logic [ROW_W-1:0] wr_row [4];
    logic [7:0]       wr_data [4];
    logic [3:0]       wr_en;

    logic [ROW_W-1:0] head_row;
    logic [1:0]       head_lane;
    logic [ROW_W-1:0] cur_row;
    logic [1:0]       cur_lane;
    logic [31:0]      word;
    logic [3:0][7:0]  new_word;
    logic [ENTRY_W-1:0] rd_entry;
    logic             cmd_ok;

    assign o_pop      = (r_state == ST_FETCH) && i_avail;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_done     = r_done;
    assign o_res      = r_res;

    assign head_row  = i_head.addr[BA_W-1:2];
    assign head_lane = i_head.addr[1:0];
    assign cur_row   = r_cmd.addr[BA_W-1:2];
    assign cur_lane  = r_cmd.addr[1:0];
    assign cmd_ok    = (r_cmd.status == ST_OK);

    // Read rows: lanes below the start lane wrap into the next row
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            rd_row[b] = head_row + ROW_W'(2'(b) < head_lane);
        end
    end

    // Gather the little-endian word starting at the entry's lane
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            word[8*i +: 8] = r_rdata[cur_lane + 2'(i)];
        end
    end

    // Extract the entry for reads
    always_comb begin
        case (r_cmd.kind)
            KIND_FAT12: begin
                rd_entry = r_cmd.odd ? ENTRY_W'(word[15:4]) : ENTRY_W'(word[11:0]);
            end
            KIND_FAT16: begin
                rd_entry = ENTRY_W'(word[15:0]);
            end
            default: begin
                rd_entry = word[ENTRY_W-1:0];
            end
        endcase
    end

    // Merge the new value, keeping neighbor nibble or reserved top bits
    always_comb begin
        case (r_cmd.kind)
            KIND_FAT12: begin
                if (r_cmd.odd) begin
                    new_word = {16'b0, r_cmd.value[11:0], word[3:0]};
                end else begin
                    new_word = {16'b0, word[15:12], r_cmd.value[11:0]};
                end
            end
            KIND_FAT16: begin
                new_word = {16'b0, r_cmd.value[15:0]};
            end
            default: begin
                new_word = {word[31:28], r_cmd.value};
            end
        endcase
    end

    // Write port per lane: clearing pass, entry write-back or raw byte load
    always_comb begin
        logic [1:0] idx;
        for (int b = 0; b < 4; b++) begin
            idx        = 2'(b) - cur_lane;
            wr_row[b]  = cur_row + ROW_W'(2'(b) < cur_lane);
            wr_data[b] = new_word[idx];
            wr_en[b]   = 1'b0;
            if (r_state == ST_CLEAR) begin
                wr_row[b]  = r_clr_row;
                wr_data[b] = 8'h00;
                wr_en[b]   = 1'b1;
            end else if (r_state == ST_EXEC && cmd_ok) begin
                if (r_cmd.op == OP_WRITE) begin
                    wr_en[b] = (r_cmd.kind == KIND_FAT32) || !idx[1];
                end else if (r_cmd.op == OP_LOAD) begin
                    wr_row[b]  = cur_row;
                    wr_data[b] = r_cmd.value[7:0];
                    wr_en[b]   = (2'(b) == cur_lane);
                end
            end
        end
    end

    // Byte lanes of the store
    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [7:0] r_mem [ROWS];

        always_ff @(posedge i_clk) begin
            if (wr_en[g]) begin
                r_mem[wr_row[g]] <= wr_data[g];
            end
            if (o_pop) begin
                r_rdata[g] <= r_mem[rd_row[g]];
            end
        end
    end

    // Sequence: clear after reset, then fetch and execute each command
    always_comb begin
        n_state   = r_state;
        n_clr_row = r_clr_row;
        n_dirty   = r_dirty;
        case (r_state)
            ST_CLEAR: begin
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (i_avail) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_cmd.op == OP_WRITE && cmd_ok) begin
                    n_dirty = 1'b1;
                end else if (r_cmd.op == OP_CLEAR) begin
                    n_dirty = 1'b0;
                end
                n_state = ST_FETCH;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Form the result
    always_comb begin
        n_res.status    = r_cmd.status;
        n_res.entry_out = (r_cmd.op == OP_READ && cmd_ok) ? rd_entry : '0;
        n_res.dirty     = n_dirty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_row <= '0;
            r_dirty   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= n_clr_row;
            r_dirty   <= n_dirty;
            r_done    <= (r_state == ST_EXEC);
        end
    end

    // Hold the working command and the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (r_state == ST_EXEC) begin
            r_res <= n_res;
        end
    end

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_EXEC))
        else $error("result strobe without an execute cycle");

    a_error_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.status != ST_OK) |-> (r_res.entry_out == '0))
        else $error("failed transaction returned a nonzero entry");

    a_write_sets_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && $past(r_cmd.op == OP_WRITE && r_cmd.status == ST_OK))
        |-> r_res.dirty)
        else $error("successful entry write left dirty clear");

endmodule

// ----- src/fat_entry_access.sv -----
// ----------------------------------------------------------------------------
// fat_entry_access: FAT12/FAT16/FAT32 table entry access unit
// Reads and writes cluster entries in an on-chip little-endian byte store,
// loads raw bytes, and tracks a dirty flag.
//
//   Channel   Handshake                  Payload
//   request   start / busy               i_req  (t_fae_req)
//   result    o_done, one-cycle strobe   o_res  (t_fae_res)
//   config    APB psel/penable/pwrite    table_kind @0x0, cluster_count @0x4
//
// - The back end runs each transaction as a byte-lane read step and an
//   execute/write-back step on the byte lanes; the result strobe is
//   registered and follows in the cycle after execute.
// - The two-entry queue takes up to two more requests while the back end
//   is working.
// - After reset the store is cleared one 4-byte row per cycle, with busy high.
// - busy is high while clearing or while the queue is full. Results cannot
//   be stalled by the receiver.
// ----------------------------------------------------------------------------
module fat_entry_access
    import fae_pkg::*;
#(
    parameter int STORE_BYTES   = STORE_BYTES_DEF,
    parameter int FIRST_CLUSTER = FIRST_CLUSTER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_fae_req    i_req,
    output logic        o_done,
    output t_fae_res    o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_kind                r_kind;
    logic [CLUSTER_W-1:0] r_count;
    t_fae_cmd             front_cmd;
    t_fae_cmd             head_cmd;
    logic                 push;
    logic                 pop;
    logic                 avail;
    logic                 full;
    logic                 clearing;

    // Configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_FAT12;
            r_count <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_COUNT) begin
                r_count <= pwdata[CLUSTER_W-1:0];
            end else begin
                r_kind <= t_kind'(pwdata[1:0]);
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_KIND) begin
            prdata = {30'b0, r_kind};
        end else begin
            prdata = {4'b0, r_count};
        end
    end

    // Accept a transaction when not busy
    assign busy = clearing || full;
    assign push = start && !busy;

    fae_front #(
        .STORE_BYTES   (STORE_BYTES),
        .FIRST_CLUSTER (FIRST_CLUSTER)
    ) u_front (
        .i_req           (i_req),
        .i_kind          (r_kind),
        .i_cluster_count (r_count),
        .o_cmd           (front_cmd)
    );

    fae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_avail (avail),
        .o_full  (full)
    );

    fae_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (avail),
        .i_head     (head_cmd),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_res      (o_res)
    );

endmodule

// ----- tb/sv/tb_fat_entry_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_entry_access: self-checking testbench for the FAT entry access block
// Drives read, write, raw load and clear-dirty transactions over start/busy
// under FAT12, FAT16, FAT32 and unsupported table settings. A tracker class
// keeps its own byte image of the table and the dirty flag. It predicts every
// result and compares it field by field with the result strobed by the block.
// ----------------------------------------------------------------------------
import fae_pkg::*;

class fat_entry_tracker;

    bit [7:0]   image [STORE_BYTES_DEF];
    bit         dirty_now;
    t_kind      kind;
    logic [27:0] count;
    t_fae_res   expected_results [$];
    int         error_count;

    function new();
        dirty_now   = 1'b0;
        kind        = KIND_FAT12;
        count       = '0;
        error_count = 0;
    endfunction

    // Mirror a register write, masked to the register width
    function void set_register(logic reg_sel, logic [31:0] data);
        if (reg_sel == REG_KIND) begin
            kind = t_kind'(data[1:0]);
        end else begin
            count = data[27:0];
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // Predict the result of one accepted transaction and queue it
    function void note_request(t_fae_req r);
        longint unsigned c;
        longint unsigned off;
        int              n;
        logic [31:0]     word;
        logic [11:0]     v12;
        t_status         st;
        logic [27:0]     entry;
        t_fae_res        res;

        st    = ST_OK;
        entry = '0;
        off   = 0;
        n     = 0;
        case (r.operation)
            OP_READ, OP_WRITE: begin
                c = r.cluster;
                if (c < FIRST_CLUSTER_DEF || c >= FIRST_CLUSTER_DEF + longint'(count)) begin
                    st = ST_BAD_CLUSTER;
                end else begin
                    case (kind)
                        KIND_FAT12: begin
                            off = (c * 3) / 2;
                            n   = 2;
                        end
                        KIND_FAT16: begin
                            off = c * 2;
                            n   = 2;
                        end
                        KIND_FAT32: begin
                            off = c * 4;
                            n   = 4;
                        end
                        default: st = ST_BAD_KIND;
                    endcase
                end
                if (st == ST_OK && off + n > STORE_BYTES_DEF) begin
                    st = ST_BAD_CLUSTER;
                end
                if (st == ST_OK) begin
                    word = '0;
                    for (int i = 0; i < n; i++) begin
                        word |= {24'd0, image[off + i]} << (8 * i);
                    end
                    if (r.operation == OP_READ) begin
                        if (kind == KIND_FAT12) begin
                            entry = c[0] ? 28'((word >> 4) & 32'h0FFF) : 28'(word & 32'h0FFF);
                        end else if (kind == KIND_FAT16) begin
                            entry = 28'(word & 32'hFFFF);
                        end else begin
                            entry = word[27:0];
                        end
                    end else begin
                        // Merge the new value, keeping neighbor nibble or reserved top bits
                        if (kind == KIND_FAT12) begin
                            v12  = r.entry_in[11:0];
                            word = c[0] ? ((word & 32'h000F) | ({20'd0, v12} << 4))
                                        : ((word & 32'hF000) | {20'd0, v12});
                        end else if (kind == KIND_FAT16) begin
                            word = {16'd0, r.entry_in[15:0]};
                        end else begin
                            word = (word & 32'hF000_0000) | {4'd0, r.entry_in};
                        end
                        for (int i = 0; i < n; i++) begin
                            image[off + i] = word[8 * i +: 8];
                        end
                        dirty_now = 1'b1;
                    end
                end
            end
            OP_LOAD: begin
                if (r.load_address < STORE_BYTES_DEF) begin
                    image[r.load_address] = r.load_byte;
                end else begin
                    st = ST_BAD_CLUSTER;
                end
            end
            default: dirty_now = 1'b0;
        endcase
        res.status    = st;
        res.entry_out = entry;
        res.dirty     = dirty_now;
        expected_results.push_back(res);
    endfunction

    // Compare one strobed result with the oldest prediction
    function void check_result(t_fae_res got);
        t_fae_res want;

        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, status %0d entry %07h dirty %0d",
                     $time, got.status, got.entry_out, got.dirty);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            error_count++;
        end
        if (got.entry_out !== want.entry_out) begin
            $display("%0t: entry_out mismatch, expected %07h, actual %07h",
                     $time, want.entry_out, got.entry_out);
            error_count++;
        end
        if (got.dirty !== want.dirty) begin
            $display("%0t: dirty mismatch, expected %0d, actual %0d",
                     $time, want.dirty, got.dirty);
            error_count++;
        end
    endfunction

endclass

module tb_fat_entry_access;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_fae_req    i_req;
    logic        o_done;
    t_fae_res    o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fat_entry_tracker tracker;
    int               cycle_count = 0;
    bit               no_gaps = 1'b0;

    fat_entry_access u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            tracker.check_result(o_res);
        end
    end

    function automatic t_fae_req make_request(t_op op, logic [27:0] c, logic [27:0] value,
                                              logic [12:0] addr, logic [7:0] data);
        t_fae_req r;

        r.operation    = op;
        r.cluster      = c;
        r.entry_in     = value;
        r.load_address = addr;
        r.load_byte    = data;
        return r;
    endfunction

    // Random transaction, often aimed at valid clusters near the start of the table
    function automatic t_fae_req build_random_request(t_kind kind, logic [27:0] count);
        t_fae_req        r;
        longint unsigned last_valid;
        longint unsigned store_last;
        longint unsigned hi;
        int              pick;

        r.cluster      = 28'($urandom);
        r.entry_in     = 28'($urandom);
        r.load_address = 13'($urandom);
        r.load_byte    = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r.operation = OP_READ;
        end else if (pick < 70) begin
            r.operation = OP_WRITE;
        end else if (pick < 88) begin
            r.operation = OP_LOAD;
        end else begin
            r.operation = OP_CLEAR;
        end
        case (kind)
            KIND_FAT16: store_last = 4095;
            KIND_FAT32: store_last = 2047;
            default:    store_last = 5460;
        endcase
        last_valid = FIRST_CLUSTER_DEF + longint'(count) - 1;
        hi = (last_valid < store_last) ? last_valid : store_last;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if (hi < FIRST_CLUSTER_DEF) begin
                r.cluster = 28'($urandom_range(0, 3));
            end else begin
                r.cluster = 28'($urandom_range(FIRST_CLUSTER_DEF, (hi < 42) ? hi : 42));
            end
        end else if (pick < 75) begin
            r.cluster = 28'($urandom_range(0, hi + 1));
        end else if (pick < 90) begin
            case ($urandom_range(0, 5))
                0: r.cluster = 28'd0;
                1: r.cluster = 28'd1;
                2: r.cluster = 28'(last_valid);
                3: r.cluster = 28'(last_valid + 1);
                4: r.cluster = 28'(store_last);
                default: r.cluster = 28'(store_last + 1);
            endcase
        end
        // Aim half the raw loads at bytes the entry traffic touches
        if ($urandom_range(0, 1) == 0) begin
            r.load_address = 13'($urandom_range(0, 191));
        end
        return r;
    endfunction

    // Present one transaction from a falling edge and hold it until accepted
    task automatic send_request(input t_fae_req r);
        bit taken;

        start <= 1'b1;
        i_req <= r;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    // Drop start on a random share of cycles
    task automatic maybe_pause();
        while (!no_gaps && $urandom_range(0, 99) < 38) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Wait until every predicted result has arrived, then let the pipeline settle
    task automatic drain_results();
        start <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, then back to idle
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        bit done;

        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = pready;
        end
        tracker.set_register(reg_sel, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reconfigure the table; upper pwdata bits carry noise that must be masked
    task automatic set_table(input t_kind kind, input logic [27:0] count);
        logic [31:0] noise;

        drain_results();
        noise = $urandom;
        write_register(REG_KIND, {noise[31:2], kind});
        noise = $urandom;
        write_register(REG_COUNT, {noise[31:28], count});
    endtask

    task automatic run_random(input t_kind kind, input logic [27:0] count, input int n);
        set_table(kind, count);
        for (int i = 0; i < n; i++) begin
            maybe_pause();
            send_request(build_random_request(kind, count));
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: no valid cluster at all
        send_request(make_request(OP_READ, 28'd2, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_WRITE, 28'h0FFFFFFF, 28'h0FFFFFFF, 13'd0, 8'd0));
        send_request(make_request(OP_LOAD, 28'd0, 28'd0, 13'h1FFF, 8'hFF));
        send_request(make_request(OP_CLEAR, 28'd0, 28'd0, 13'd0, 8'd0));

        // FAT12: packed even and odd entries sharing a byte, store edge
        set_table(KIND_FAT12, 28'h0FFFFFFF);
        send_request(make_request(OP_WRITE, 28'd2, 28'h0FFFFFFF, 13'd0, 8'd0));
        send_request(make_request(OP_WRITE, 28'd3, 28'h0000ABC, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd2, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd3, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_WRITE, 28'd2, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd3, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_WRITE, 28'd5460, 28'h0000FFF, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd5460, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd5461, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd1, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd0, 28'd0, 13'd0, 8'd0));

        // FAT32: reserved top nibble kept on write, range edges
        set_table(KIND_FAT32, 28'd100);
        send_request(make_request(OP_LOAD, 28'd0, 28'd0, 13'd11, 8'hF5));
        send_request(make_request(OP_WRITE, 28'd2, 28'h0FFFFFFF, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd2, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd101, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd102, 28'd0, 13'd0, 8'd0));

        // FAT16: last entry of the store; the FAT32 top byte shows through
        set_table(KIND_FAT16, 28'd4094);
        send_request(make_request(OP_WRITE, 28'd4095, 28'h000FFFF, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd4095, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_READ, 28'd5, 28'd0, 13'd0, 8'd0));

        // Unsupported kind: range check wins over the kind check
        set_table(KIND_NONE, 28'd10);
        send_request(make_request(OP_READ, 28'd5, 28'd0, 13'd0, 8'd0));
        send_request(make_request(OP_WRITE, 28'd0, 28'h1234567, 13'd0, 8'd0));
        send_request(make_request(OP_CLEAR, 28'd0, 28'd0, 13'd0, 8'd0));

        // Random traffic over several settings, one phase back to back
        run_random(KIND_FAT12, 28'h0FFFFFFF, 170);
        no_gaps = 1'b1;
        run_random(KIND_FAT16, 28'h0FFFFFFF, 150);
        no_gaps = 1'b0;
        run_random(KIND_FAT32, 28'h0FFFFFFF, 170);
        run_random(KIND_FAT12, 28'd40, 120);
        run_random(KIND_FAT32, 28'd0, 60);
        run_random(KIND_NONE, 28'd500, 80);
        run_random(KIND_FAT16, 28'd3000, 130);
        run_random(KIND_FAT32, 28'd1500, 130);
        for (int p = 0; p < 3; p++) begin
            run_random(t_kind'($urandom_range(0, 3)), 28'($urandom_range(0, 6000)), 80);
        end

        // Wait out the last results, then report
        drain_results();
        repeat (20) @(negedge i_clk);
        if (tracker.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tracker.pending());
            tracker.error_count++;
        end
        if (tracker.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fae_pkg.sv
src/fae_front.sv
src/fae_queue.sv
src/fae_back.sv
src/fat_entry_access.sv
tb/sv/tb_fat_entry_access.sv
